### sv/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

  // Fixed payload formats
  localparam int unsigned COORD_BITS       = 32;
  localparam int unsigned POS_FRAC_BITS    = 16;
  localparam int unsigned POS_BITS         = POS_FRAC_BITS + 1;
  localparam int unsigned DEF_MAX_VERTICES = 64;

  // Shared multiplier operands: signed coefficient by unsigned fraction
  localparam int unsigned MUL_A_BITS = COORD_BITS + 5;
  localparam int unsigned MUL_B_BITS = POS_FRAC_BITS;
  localparam int unsigned MUL_P_BITS = MUL_A_BITS + MUL_B_BITS + 1;

  // Accumulator for the doubled cubic sum
  localparam int unsigned ACC_BITS = COORD_BITS + POS_FRAC_BITS + 7;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SEG,
    FSM_WSQ,
    FSM_WCUBE,
    FSM_READ,
    FSM_AXIS,
    FSM_PUSH
  } fsm_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vertex_t;

  typedef struct packed {
    cmd_e                         cmd;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic [POS_BITS-1:0]          sample_position;
  } crs_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    status_e                      status;
  } crs_rsp_t;

endpackage

### sv/crs_vertex_ram.sv
`timescale 1ns / 1ps

module crs_vertex_ram #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned ADDR_BITS  = 6
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [ADDR_BITS-1:0]  wr_addr_i,
  input  crs_pkg::vertex_t      wr_data_i,
  input  logic                  rd_en_i,
  input  logic [ADDR_BITS-1:0]  rd_addr_i,
  output crs_pkg::vertex_t      rd_data_o
);
  import crs_pkg::*;

  vertex_t mem_q [DEPTH];
  vertex_t rd_data_q;

  // Write one vertex
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/crs_mul_unit.sv
`timescale 1ns / 1ps

module crs_mul_unit (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [crs_pkg::MUL_A_BITS-1:0]   a_i,
  input  logic [crs_pkg::MUL_B_BITS-1:0]          b_i,
  output logic signed [crs_pkg::MUL_P_BITS-1:0]   prod_o
);
  import crs_pkg::*;

  logic signed [MUL_P_BITS-1:0] prod_d;
  logic signed [MUL_P_BITS-1:0] prod_q;

  // Signed coefficient times unsigned fraction
  assign prod_d = a_i * $signed({1'b0, b_i});

  // Hold the product until the next issue
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### sv/catmull_rom_curve_sampler_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload     Handshake
// request   in         crs_req_t   req_valid_i / req_ready_o
// response  out        crs_rsp_t   rsp_valid_o / rsp_ready_i
//
// Clear, append and no-op requests go from idle straight to the push state; a
// sample first runs the segment, square, cube, read and axis states.
// The sample time is set by the one shared multiplier (three products for
// the segment and the fraction powers, three per axis) and the single read
// port of the vertex store (four reads). Reset empties the store; the
// contents need no clearing pass. A stalled response holds in its output
// register while the next request is taken; a finished one waits there.
module catmull_rom_curve_sampler_unit #(
  parameter int unsigned MAX_VERTICES = crs_pkg::DEF_MAX_VERTICES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  crs_pkg::crs_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output crs_pkg::crs_rsp_t rsp_o
);
  import crs_pkg::*;

  localparam int unsigned IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned F  = POS_FRAC_BITS;
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned SH = ACC_BITS - F - 1;

  localparam logic [2*F-1:0] HALF = (2*F)'(1) << (F - 1);

  // Control state
  fsm_e            state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [1:0]      ax_q, ax_d;
  logic [2:0]      stp_q, stp_d;
  logic            rsp_valid_q, rsp_valid_d;

  // Datapath registers
  logic            kfull_q, kfull_d;
  logic [F-1:0]    kl_q, kl_d;
  logic [IW-1:0]   maxi_q, maxi_d;
  logic [IW-1:0]   seg_q, seg_d;
  logic [F-1:0]    w_q, w_d;
  logic [F-1:0]    w2_q, w2_d;
  logic [F-1:0]    w3_q, w3_d;
  vertex_t         v_q [4];
  vertex_t         v_d [4];
  logic signed [MUL_A_BITS-1:0] a_q, a_d, b_q, b_d, d0_q, d0_d;
  logic signed [ACC_BITS-1:0]   acc_q, acc_d;
  crs_rsp_t        res_q, res_d;
  crs_rsp_t        rsp_q, rsp_d;

  // Shared unit and store ports
  logic                          mul_en;
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic [MUL_B_BITS-1:0]         mul_b;
  logic signed [MUL_P_BITS-1:0]  prod;
  logic                          wr_en;
  vertex_t                       wr_data;
  logic                          rd_en;
  logic [IW-1:0]                 rd_addr;
  vertex_t                       rd_data;

  // Working values
  logic [IW-1:0]                 seg_nx;
  logic [F-1:0]                  w_nx;
  logic [2*F-1:0]                prod_rnd;
  logic [F-1:0]                  frac_rnd;
  logic signed [MUL_A_BITS-1:0]  p [4];
  logic signed [MUL_A_BITS-1:0]  dd, dd0, dd1;
  logic signed [ACC_BITS-1:0]    sum;
  logic signed [SH-1:0]          sh;
  logic signed [C-1:0]           sat;

  // Clamp neighbor index seg-1+j to the filled range
  function automatic logic [IW-1:0] clamp_idx(input logic [IW-1:0] seg,
                                              input logic [IW-1:0] maxi,
                                              input logic [1:0]    j);
    logic signed [IW+2:0] t;
    t = $signed({3'b000, seg}) + $signed({{(IW+1){1'b0}}, j})
        - $signed((IW+3)'(1));
    if (t < 0) begin
      return '0;
    end else if (t > $signed({3'b000, maxi})) begin
      return maxi;
    end
    return t[IW-1:0];
  endfunction

  crs_vertex_ram #(
    .DEPTH     (MAX_VERTICES),
    .ADDR_BITS (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  crs_mul_unit u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign wr_data.x = req_i.coord_x;
  assign wr_data.y = req_i.coord_y;
  assign wr_data.z = req_i.coord_z;

  // Round a fraction product back to F bits, half up
  assign prod_rnd = prod[2*F-1:0] + HALF;
  assign frac_rnd = prod_rnd[2*F-1:F];

  // Segment and fraction from the position product
  always_comb begin
    if (kfull_q) begin
      seg_nx = maxi_q;
      w_nx   = '0;
    end else begin
      seg_nx = prod[F+IW-1:F];
      w_nx   = prod[F-1:0];
    end
  end

  // Select the current axis of the four neighbors
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      case (ax_q)
        2'd0:    p[j] = MUL_A_BITS'(v_q[j].x);
        2'd1:    p[j] = MUL_A_BITS'(v_q[j].y);
        default: p[j] = MUL_A_BITS'(v_q[j].z);
      endcase
    end
  end

  assign dd  = p[1] - p[2];
  assign dd0 = p[2] - p[0];
  assign dd1 = p[3] - p[1];

  // Final sum, halve with rounding, saturate
  assign sum = acc_q + ACC_BITS'(prod);
  assign sh  = sum[ACC_BITS-1:F+1];
  always_comb begin
    if (sh[SH-1:C-1] != '0 && sh[SH-1:C-1] != '1) begin
      sat = sh[SH-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    end else begin
      sat = sh[C-1:0];
    end
  end

  // Sequencer: next state, datapath updates and port controls
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    ax_d        = ax_q;
    stp_d       = stp_q;
    kfull_d     = kfull_q;
    kl_d        = kl_q;
    maxi_d      = maxi_q;
    seg_d       = seg_q;
    w_d         = w_q;
    w2_d        = w2_q;
    w3_d        = w3_q;
    v_d         = v_q;
    a_d         = a_q;
    b_d         = b_q;
    d0_d        = d0_q;
    acc_d       = acc_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    req_ready_o = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          res_d   = '0;
          state_d = FSM_PUSH;
          case (req_i.cmd)
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_APPEND: begin
              if (count_q >= CW'(MAX_VERTICES)) begin
                res_d.status = STATUS_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_SAMPLE: begin
              if (count_q == '0) begin
                res_d.status = STATUS_EMPTY;
              end else begin
                maxi_d  = IW'(count_q - CW'(1));
                kfull_d = req_i.sample_position[F];
                kl_d    = req_i.sample_position[F-1:0];
                state_d = FSM_SEG;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Scale the position by the last index
      FSM_SEG: begin
        mul_en  = 1'b1;
        mul_a   = $signed({{(MUL_A_BITS-IW){1'b0}}, maxi_q});
        mul_b   = kl_q;
        state_d = FSM_WSQ;
      end

      // Latch segment and fraction, square the fraction
      FSM_WSQ: begin
        seg_d   = seg_nx;
        w_d     = w_nx;
        mul_en  = 1'b1;
        mul_a   = $signed({{(MUL_A_BITS-F){1'b0}}, w_nx});
        mul_b   = w_nx;
        state_d = FSM_WCUBE;
      end

      // Round the square, form the cube, issue the first read
      FSM_WCUBE: begin
        w2_d    = frac_rnd;
        mul_en  = 1'b1;
        mul_a   = $signed({{(MUL_A_BITS-F){1'b0}}, frac_rnd});
        mul_b   = w_q;
        rd_en   = 1'b1;
        rd_addr = clamp_idx(seg_q, maxi_q, 2'd0);
        cnt_d   = 3'd1;
        state_d = FSM_READ;
      end

      // Collect the four neighbors, one read a cycle
      FSM_READ: begin
        w3_d = frac_rnd;
        v_d[2'(cnt_q - 3'd1)] = rd_data;
        if (cnt_q < 3'd4) begin
          rd_en   = 1'b1;
          rd_addr = clamp_idx(seg_q, maxi_q, cnt_q[1:0]);
          cnt_d   = cnt_q + 3'd1;
        end else begin
          ax_d    = '0;
          stp_d   = '0;
          state_d = FSM_AXIS;
        end
      end

      // Evaluate the cubic on one axis at a time
      FSM_AXIS: begin
        case (stp_q)
          3'd0: begin
            a_d   = (dd <<< 2) + dd0 + dd1;
            b_d   = -((dd <<< 2) + (dd <<< 1)) - (dd0 <<< 1) - dd1;
            d0_d  = dd0;
            acc_d = (ACC_BITS'(p[1]) <<< (F + 1)) + (ACC_BITS'(1) <<< F);
            stp_d = 3'd1;
          end
          3'd1: begin
            mul_en = 1'b1;
            mul_a  = a_q;
            mul_b  = w3_q;
            stp_d  = 3'd2;
          end
          3'd2: begin
            acc_d  = sum;
            mul_en = 1'b1;
            mul_a  = b_q;
            mul_b  = w2_q;
            stp_d  = 3'd3;
          end
          3'd3: begin
            acc_d  = sum;
            mul_en = 1'b1;
            mul_a  = d0_q;
            mul_b  = w_q;
            stp_d  = 3'd4;
          end
          3'd4: begin
            case (ax_q)
              2'd0:    res_d.out_x = sat;
              2'd1:    res_d.out_y = sat;
              default: res_d.out_z = sat;
            endcase
            stp_d = 3'd0;
            if (ax_q == 2'd2) begin
              state_d = FSM_PUSH;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end
          default: begin
            stp_d = 3'd0;
          end
        endcase
      end

      // Load the response register once it is free
      FSM_PUSH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      ax_q        <= '0;
      stp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      ax_q        <= ax_d;
      stp_q       <= stp_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kfull_q <= kfull_d;
    kl_q    <= kl_d;
    maxi_q  <= maxi_d;
    seg_q   <= seg_d;
    w_q     <= w_d;
    w2_q    <= w2_d;
    w3_q    <= w3_d;
    v_q     <= v_d;
    a_q     <= a_d;
    b_q     <= b_d;
    d0_q    <= d0_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
